// File: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros for the checker modules.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// File: rtl/lebi_pkg.sv
// lebi_pkg: shared types, constants and control structs of the left-edge binder.
// Depends on nothing.
package lebi_pkg;

   localparam int unsigned LIMIT_W        = 5;
   localparam int unsigned FIELD_CYCLE_W  = 16;
   localparam int unsigned INDEX_W        = 4;
   localparam int unsigned DEF_MAX_INST   = 16;
   localparam int unsigned DEF_CYCLE_BITS = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_OVER = 1'b1;

   typedef struct packed {
      logic [FIELD_CYCLE_W-1:0] start_cycle;
      logic [FIELD_CYCLE_W-1:0] end_cycle;
      logic                     group_first;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] instance_index;
      logic               status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture transaction, restart scan
      logic rd;        // read slot at scan index
      logic step;      // advance scan index
      logic take_hit;  // bind to scanned slot
      logic take_new;  // open a new slot
      logic over;      // report over-limit
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done; // scan index reached opened count
      logic hit;       // read slot ends before start
      logic at_limit;  // opened count at or above effective limit
   } dp_stat_type;

endpackage

// File: rtl/lebi_ram.sv
// lebi_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lebi_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lebi_ctrl.sv
// lebi_ctrl: sequencer of the slot scan, result strobe and busy flag.
// Depends on lebi_pkg.
module lebi_ctrl
   import lebi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               if (stat.at_limit) begin
                  cmd.over = 1'b1;
               end else begin
                  cmd.take_new = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign strobe_in = cmd.take_hit | cmd.take_new | cmd.over;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// File: rtl/lebi_dp.sv
// lebi_dp: limit register, opened count, scan index, slot RAM and result register.
// Depends on lebi_pkg and lebi_ram.
module lebi_dp
   import lebi_pkg::*;
#(
   parameter int unsigned MAX_INSTANCES = DEF_MAX_INST,
   parameter int unsigned CYCLE_BITS    = DEF_CYCLE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_item,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   input  ctrl_cmd_type       cmd,
   output dp_stat_type        stat,
   output rsp_type            rsp_item
);

   localparam int unsigned ADDR_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
   localparam int unsigned CNT_W  = (ADDR_W + 1 > LIMIT_W) ? ADDR_W + 1 : LIMIT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INSTANCES);

   logic [LIMIT_W-1:0]    limit_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [CYCLE_BITS-1:0] start_ff, end_ff;
   rsp_type               rsp_ff;
   logic [CNT_W-1:0]      limit_ext, eff_limit;
   logic [CYCLE_BITS-1:0] slot_end;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // limit clamped to capacity
   assign limit_ext = CNT_W'(limit_ff);
   assign eff_limit = (limit_ext > MAX_CNT) ? MAX_CNT : limit_ext;

   // opened count and scan index
   always_comb begin
      count_in = count_ff;
      scan_in  = scan_ff;
      if (cmd.load) begin
         scan_in = '0;
         if (req_item.group_first) begin
            count_in = '0;
         end
      end
      if (cmd.step) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (cmd.take_new) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
   end

   // interval capture, masked to the cycle width
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         start_ff <= CYCLE_BITS'(req_item.start_cycle);
         end_ff   <= CYCLE_BITS'(req_item.end_cycle);
      end
   end

   // slot store: write on bind, read at scan index
   assign wr_en   = cmd.take_hit | cmd.take_new;
   assign wr_addr = cmd.take_hit ? scan_ff[ADDR_W-1:0] : count_ff[ADDR_W-1:0];

   lebi_ram #(
      .WIDTH (CYCLE_BITS),
      .DEPTH (MAX_INSTANCES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (end_ff),
      .rd_en   (cmd.rd),
      .rd_addr (scan_ff[ADDR_W-1:0]),
      .rd_data (slot_end)
   );

   // status to controller
   assign stat.scan_done = (scan_ff == count_ff);
   assign stat.hit       = (slot_end < start_ff);
   assign stat.at_limit  = (count_ff >= eff_limit);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.take_hit) begin
         rsp_ff.instance_index <= scan_ff[INDEX_W-1:0];
         rsp_ff.status         <= STATUS_OK;
      end else if (cmd.take_new) begin
         rsp_ff.instance_index <= count_ff[INDEX_W-1:0];
         rsp_ff.status         <= STATUS_OK;
      end else if (cmd.over) begin
         rsp_ff.instance_index <= '0;
         rsp_ff.status         <= STATUS_OVER;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// File: rtl/left_edge_interval_binder_unit.sv
// left_edge_interval_binder_unit: top level of the left-edge interval binder.
// Depends on lebi_pkg, lebi_ctrl, lebi_dp (and through it lebi_ram).
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_item        taken when start & !busy
//   response  rsp_strobe, rsp_item         one-cycle strobe, no back-pressure
//   config    csr_we, csr_wdata            written when csr_we, no wait
//
// One transaction at a time. Binding to opened slot k scans slots 0 through k;
// opening a new slot or reporting over-limit first scans all n opened slots.
// Each slot visited costs a RAM read (registered) plus a compare: one read port.
// The result strobe rises in the same cycle that busy drops, so a new transaction
// may be accepted in the strobe cycle. Synchronous reset clears the opened
// count and sets the limit to 16; slot contents are not cleared.
module left_edge_interval_binder_unit
   import lebi_pkg::*;
#(
   parameter int unsigned MAX_INSTANCES = DEF_MAX_INST,
   parameter int unsigned CYCLE_BITS    = DEF_CYCLE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_strobe,
   output rsp_type            rsp_item,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   lebi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   lebi_dp #(
      .MAX_INSTANCES (MAX_INSTANCES),
      .CYCLE_BITS    (CYCLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/lebi_checker.sv
// lebi_checker: port-level assertions for the binder, bound to the top level.
// Depends on lebi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lebi_checker
   import lebi_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // an accepted transaction makes the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // a result is only issued after a busy cycle, and busy has dropped
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_strobe, $past(busy) && !busy)

   // strobe never repeats back to back
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)

   // over-limit carries index zero
   `ASSERT_SAME(a_over_index, clock, reset,
      rsp_strobe && (rsp_item.status == STATUS_OVER), rsp_item.instance_index == '0)

endmodule

bind left_edge_interval_binder_unit lebi_checker u_lebi_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

// File: tb/tb_left_edge_interval_binder_unit.sv
// tb_left_edge_interval_binder_unit: self-checking testbench for the left-edge interval binder.
// Depends on lebi_pkg and left_edge_interval_binder_unit; predicts each binding
// in SystemVerilog and compares every response transaction against it.
module tb_left_edge_interval_binder_unit
   import lebi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_SLOTS  = DEF_MAX_INST;
   localparam int          IDLE_LIMIT = 2000;
   localparam int          SETTLE_CYC = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_item = '0;
   logic               rsp_strobe;
   rsp_type            rsp_item;
   logic               csr_we = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   // binder state mirror
   logic [LIMIT_W-1:0]       bound_limit;
   logic [FIELD_CYCLE_W-1:0] slot_end [NUM_SLOTS];
   int unsigned              open_count;

   rsp_type expected_bind[$];
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;

   left_edge_interval_binder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Left-edge binding of one interval against the mirrored slots
   function automatic rsp_type bind_interval(req_type it);
      int unsigned eff_limit;
      int unsigned pick;
      bit          found;
      rsp_type     r;
      eff_limit = (bound_limit > NUM_SLOTS) ? NUM_SLOTS : bound_limit;
      found     = 1'b0;
      pick      = 0;
      if (it.group_first)
         open_count = 0;
      for (int unsigned k = 0; k < open_count; k++) begin
         if (!found && slot_end[k] < it.start_cycle) begin
            found = 1'b1;
            pick  = k;
         end
      end
      if (!found) begin
         if (open_count >= eff_limit) begin
            r.instance_index = '0;
            r.status         = STATUS_OVER;
            return r;
         end
         pick       = open_count;
         open_count = open_count + 1;
      end
      slot_end[pick]   = it.end_cycle;
      r.instance_index = pick[INDEX_W-1:0];
      r.status         = STATUS_OK;
      return r;
   endfunction

   // Track config writes and accepted transactions, check each response
   always @(posedge clock) begin
      if (reset) begin
         bound_limit = LIMIT_RESET;
         open_count  = 0;
         expected_bind.delete();
      end else begin
         if (csr_we)
            bound_limit = csr_wdata;
         if (start && !busy)
            expected_bind = {expected_bind, bind_interval(req_item)};
         if (rsp_strobe) begin
            if (expected_bind.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t unexpected response: index %0d status %0b",
                           $realtime, rsp_item.instance_index, rsp_item.status);
            end else begin
               rsp_type want;
               want = expected_bind.pop_front();
               if (rsp_item.instance_index !== want.instance_index ||
                   rsp_item.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t mismatch: want index %0d status %0b, got index %0d status %0b",
                              $realtime, want.instance_index, want.status,
                              rsp_item.instance_index, rsp_item.status);
               end
            end
         end
      end
   end

   // Watchdog: cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Present one interval, hold until taken, then idle at the given rate
   task automatic send_interval(input req_type it, input int idle_pct);
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_fields(input int unsigned s, input int unsigned e, input bit g);
      req_type it;
      it.start_cycle = s[FIELD_CYCLE_W-1:0];
      it.end_cycle   = e[FIELD_CYCLE_W-1:0];
      it.group_first = g;
      send_interval(it, 0);
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_bindings();
      start <= 1'b0;
      @(posedge clock);
      while (expected_bind.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_limit(input logic [LIMIT_W-1:0] value);
      drain_bindings();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Reset limit: open all sixteen instances, then one more is over limit
   task automatic test_fill_reset_limit();
      for (int unsigned k = 0; k < NUM_SLOTS; k++)
         send_fields(0, 16'hFFFF, k == 0);
      send_fields(16'hFFFF, 0, 1'b0);
      drain_bindings();
   endtask

   // Zero limit: group start still clears, nothing can be opened
   task automatic test_zero_limit();
      program_limit('0);
      send_fields(0, 0, 1'b1);
      send_fields(1000, 1000, 1'b0);
      drain_bindings();
   endtask

   // Limit above capacity, inverted interval stored as given
   task automatic test_inverted_above_capacity();
      program_limit('1);
      send_fields(100, 5, 1'b1);
      send_fields(6, 6, 1'b0);
      send_fields(6, 16'hFFFF, 1'b0);
      send_fields(7, 7, 1'b0);
      drain_bindings();
   endtask

   // Single instance: overlap is over limit, reuse after the end
   task automatic test_single_instance();
      program_limit(5'd1);
      send_fields(0, 10, 1'b1);
      send_fields(5, 5, 1'b0);
      send_fields(11, 11, 1'b0);
      drain_bindings();
   endtask

   // Mostly sorted groups with random content, some unsorted noise
   task automatic test_random_phase(input logic [LIMIT_W-1:0] lim, input int idle_pct,
                                    input int n_items);
      int          sent;
      int          grp_len;
      int          g;
      int unsigned cur;
      int unsigned span;
      req_type     it;
      program_limit(lim);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            it.start_cycle = 16'($urandom_range(0, 65535));
            it.end_cycle   = 16'($urandom_range(0, 65535));
            it.group_first = 1'($urandom_range(1));
            send_interval(it, idle_pct);
            sent++;
         end else begin
            grp_len = $urandom_range(1, 24);
            cur     = $urandom_range(0, 65535);
            for (g = 0; g < grp_len && sent < n_items; g++) begin
               span = ($urandom_range(7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 12);
               it.start_cycle = cur[FIELD_CYCLE_W-1:0];
               it.end_cycle   = (cur + span > 65535) ? 16'hFFFF : 16'(cur + span);
               it.group_first = (g == 0);
               send_interval(it, idle_pct);
               sent++;
               cur = cur + $urandom_range(0, 4);
               if (cur > 65535)
                  cur = 65535;
            end
         end
      end
      drain_bindings();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_reset_limit();
      test_zero_limit();
      test_inverted_above_capacity();
      test_single_instance();

      test_random_phase(5'd4, 0, 200);
      test_random_phase(5'd16, 86, 150);
      test_random_phase(5'd1, 0, 100);
      test_random_phase(5'd31, 9, 150);
      test_random_phase(5'd0, 0, 50);
      test_random_phase(5'd8, 86, 100);

      drain_bindings();
      repeat (SETTLE_CYC) @(posedge clock);
      if (expected_bind.size() != 0) begin
         mismatch_count++;
         $display("%0d expected responses never arrived", expected_bind.size());
      end
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
